// File: design/hmts_pkg.sv
// hmts_pkg: shared widths, codes and types for the heightmap triangle sampler.
// No dependencies; imported by hmts_bank and heightmap_triangle_sampler_top.
`timescale 1ns / 1ps

package hmts_pkg;

  // Fixed field widths
  localparam int POS_W      = 24;  // Q15.8 world position
  localparam int HGT_W      = 16;  // Q7.8 height
  localparam int IDX_W      = 8;   // sample column / row index
  localparam int GRID_W     = 9;   // grid size registers
  localparam int NUM_BANKS  = 4;   // store banked by row and column parity
  localparam int BANK_SEL_W = 2;   // {row parity, column parity}

  // Configuration port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [1:0] REG_OFFSET_X    = 2'd0;
  localparam logic [1:0] REG_OFFSET_Z    = 2'd1;
  localparam logic [1:0] REG_GRID_WIDTH  = 2'd2;
  localparam logic [1:0] REG_GRID_LENGTH = 2'd3;

  // Item opcode
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  // Per-bank access control
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } bank_ctl_t;

endpackage

// File: design/heightmap_triangle_sampler_top.sv
// Heightmap triangle sampler, top level: pipeline, config registers, banked store.
// Depends on hmts_pkg and hmts_bank.
`timescale 1ns / 1ps

// The block takes one item per clock while in_stall is low, writes and queries
// mixed freely, and a query's result appears on out_valid after it passes the
// stages offset subtract, cell split and triangle pick, store read, corner
// multiply, and sum and round. A write updates the store in the store-read
// stage, in order with the queries around it, so a query that follows a write
// sees the new sample. The height store is split into four single-port banks
// by row and column parity; the four corners of any cell fall in four
// different banks, which is what allows all corner reads in the same cycle.
// The store has no reset and no clearing pass: every sample a query touches
// must have been written first. Writes produce no result item.
module heightmap_triangle_sampler_top
  import hmts_pkg::*;
#(
  parameter int MAX_SIDE  = 256,
  parameter int FRAC_BITS = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_op,
  input  logic signed [POS_W-1:0]  in_pos_x,
  input  logic signed [POS_W-1:0]  in_pos_z,
  input  logic [IDX_W-1:0]         in_sample_col,
  input  logic [IDX_W-1:0]         in_sample_row,
  input  logic signed [HGT_W-1:0]  in_sample_height,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [HGT_W-1:0]  out_height,
  output logic                     out_outside,
  // configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_AW-1:0]        paddr,
  input  logic [CFG_DW-1:0]        pwdata,
  output logic [CFG_DW-1:0]        prdata,
  output logic                     pready
);

  localparam int HALF_SIDE = (MAX_SIDE + 1) / 2;
  localparam int HW        = (HALF_SIDE > 1) ? $clog2(HALF_SIDE) : 1;
  localparam int AW        = 2 * HW;
  localparam int GX_W      = POS_W + 1 - FRAC_BITS;
  localparam int WT_W      = FRAC_BITS + 1;
  localparam int PROD_W    = HGT_W + WT_W + 1;
  localparam int ACC_W     = PROD_W + 2;
  localparam logic [WT_W-1:0]  ONE_W      = WT_W'(1) << FRAC_BITS;
  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_BITS - 1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [POS_W-1:0] offset_x_r, offset_z_r;
  logic [GRID_W-1:0]       grid_width_r, grid_length_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_x_r    <= '0;
      offset_z_r    <= '0;
      grid_width_r  <= GRID_W'(256);
      grid_length_r <= GRID_W'(256);
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_OFFSET_X:    offset_x_r    <= pwdata[POS_W-1:0];
        REG_OFFSET_Z:    offset_z_r    <= pwdata[POS_W-1:0];
        REG_GRID_WIDTH:  grid_width_r  <= pwdata[GRID_W-1:0];
        REG_GRID_LENGTH: grid_length_r <= pwdata[GRID_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_OFFSET_X:    prdata = CFG_DW'(offset_x_r);
      REG_OFFSET_Z:    prdata = CFG_DW'(offset_z_r);
      REG_GRID_WIDTH:  prdata = CFG_DW'(grid_width_r);
      REG_GRID_LENGTH: prdata = CFG_DW'(grid_length_r);
      default:         prdata = '0;
    endcase
  end

  // Grid sizes clamped to the store side
  logic [31:0] w_lim, l_lim;
  assign w_lim = (32'(grid_width_r) > 32'(MAX_SIDE)) ? 32'(MAX_SIDE) : 32'(grid_width_r);
  assign l_lim = (32'(grid_length_r) > 32'(MAX_SIDE)) ? 32'(MAX_SIDE) : 32'(grid_length_r);

  // ---------------------------------------------------------------------------
  // Pipeline flow control: a stage loads when empty or when the next one moves
  // ---------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy_out;

  assign rdy_out  = !out_valid_r || !out_stall;
  assign rdy4     = !v4_r || rdy_out;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;

  // ---------------------------------------------------------------------------
  // Stage 1: subtract the world offset at full width
  // ---------------------------------------------------------------------------
  op_t                     op1_r;
  logic signed [POS_W:0]   tx1_r, tz1_r;
  logic [IDX_W-1:0]        col1_r, row1_r;
  logic [HGT_W-1:0]        hgt1_r;
  logic signed [POS_W:0]   tx_nxt, tz_nxt;

  assign tx_nxt = (POS_W+1)'(in_pos_x) - (POS_W+1)'(offset_x_r);
  assign tz_nxt = (POS_W+1)'(in_pos_z) - (POS_W+1)'(offset_z_r);

  always_ff @(posedge clk) begin
    if (rdy1) begin
      op1_r  <= op_t'(in_op);
      tx1_r  <= tx_nxt;
      tz1_r  <= tz_nxt;
      col1_r <= in_sample_col;
      row1_r <= in_sample_row;
      hgt1_r <= in_sample_height;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: cell split, outside test, triangle pick, weights, bank addresses
  // ---------------------------------------------------------------------------
  logic [GX_W-1:0]           gx, gz;
  logic [31:0]               gx32, gz32, col32, row32;
  logic [FRAC_BITS-1:0]      fx, fz;
  logic [WT_W-1:0]           fsum;
  logic                      lower, in_grid, xp, zp;
  logic [WT_W-1:0]           w0_nxt, w1_nxt, w2_nxt;
  logic [BANK_SEL_W-1:0]     c0_nxt, c1_nxt, c2_nxt;
  logic [BANK_SEL_W-1:0]     ca, cb, cc, cd;
  logic [AW-1:0]             raddr_nxt [NUM_BANKS];
  logic                      wok_nxt;
  logic [BANK_SEL_W-1:0]     wbank_nxt;
  logic [AW-1:0]             waddr_nxt;

  assign gx    = tx1_r[POS_W:FRAC_BITS];
  assign gz    = tz1_r[POS_W:FRAC_BITS];
  assign gx32  = 32'(gx);
  assign gz32  = 32'(gz);
  assign fx    = tx1_r[FRAC_BITS-1:0];
  assign fz    = tz1_r[FRAC_BITS-1:0];
  assign fsum  = WT_W'(fx) + WT_W'(fz);
  assign lower = (fsum <= ONE_W);  // tie goes to the lower triangle

  assign in_grid = !tx1_r[POS_W] && !tz1_r[POS_W] &&
                   (gx32 + 32'd1 < w_lim) && (gz32 + 32'd1 < l_lim);

  // Corner banks: a = (x,z), b = (x+1,z), c = (x,z+1), d = (x+1,z+1)
  assign xp = gx[0];
  assign zp = gz[0];
  assign ca = {zp, xp};
  assign cb = {zp, ~xp};
  assign cc = {~zp, xp};
  assign cd = {~zp, ~xp};

  always_comb begin
    if (lower) begin
      w0_nxt = ONE_W - fsum;
      w1_nxt = WT_W'(fx);
      w2_nxt = WT_W'(fz);
      c0_nxt = ca;
      c1_nxt = cb;
      c2_nxt = cc;
    end else begin
      w0_nxt = ONE_W - WT_W'(fz);
      w1_nxt = fsum - ONE_W;
      w2_nxt = ONE_W - WT_W'(fx);
      c0_nxt = cb;
      c1_nxt = cd;
      c2_nxt = cc;
    end
  end

  // Even-parity bank holds (g+1)>>1 of the pair g, g+1; odd holds g>>1
  always_comb begin
    logic [BANK_SEL_W-1:0] bsel;
    logic [31:0]           zh, xh;
    for (int b = 0; b < NUM_BANKS; b++) begin
      bsel = BANK_SEL_W'(b);
      zh = bsel[1] ? (gz32 >> 1) : ((gz32 + 32'd1) >> 1);
      xh = bsel[0] ? (gx32 >> 1) : ((gx32 + 32'd1) >> 1);
      raddr_nxt[b] = {zh[HW-1:0], xh[HW-1:0]};
    end
  end

  // Write target; samples beyond the store are dropped
  assign col32     = 32'(col1_r);
  assign row32     = 32'(row1_r);
  assign wok_nxt   = (col32 < 32'(MAX_SIDE)) && (row32 < 32'(MAX_SIDE));
  assign wbank_nxt = {row1_r[0], col1_r[0]};
  assign waddr_nxt = {row32[HW:1], col32[HW:1]};

  op_t                   op2_r;
  logic                  out2_r, wok2_r;
  logic [WT_W-1:0]       w0_2_r, w1_2_r, w2_2_r;
  logic [BANK_SEL_W-1:0] c0_2_r, c1_2_r, c2_2_r, wbank2_r;
  logic [AW-1:0]         raddr2_r [NUM_BANKS];
  logic [AW-1:0]         waddr2_r;
  logic [HGT_W-1:0]      wdata2_r;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      op2_r    <= op1_r;
      out2_r   <= !in_grid;
      w0_2_r   <= w0_nxt;
      w1_2_r   <= w1_nxt;
      w2_2_r   <= w2_nxt;
      c0_2_r   <= c0_nxt;
      c1_2_r   <= c1_nxt;
      c2_2_r   <= c2_nxt;
      raddr2_r <= raddr_nxt;
      wok2_r   <= wok_nxt;
      wbank2_r <= wbank_nxt;
      waddr2_r <= waddr_nxt;
      wdata2_r <= hgt1_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: store access (writes land here, queries read all four banks)
  // ---------------------------------------------------------------------------
  logic [HGT_W-1:0]      rd [NUM_BANKS];
  bank_ctl_t             bank_ctl [NUM_BANKS];
  logic                  is_query2, is_write2;

  assign is_query2 = v2_r && (op2_r == OP_QUERY);
  assign is_write2 = v2_r && (op2_r == OP_WRITE);

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    logic [AW-1:0] addr;

    assign bank_ctl[b].rd_en = rdy3 && is_query2;
    assign bank_ctl[b].wr_en = rdy3 && is_write2 && wok2_r &&
                               (wbank2_r == BANK_SEL_W'(b));
    assign addr = is_write2 ? waddr2_r : raddr2_r[b];

    hmts_bank #(
      .AW (AW),
      .DW (HGT_W)
    ) u_bank (
      .clk   (clk),
      .ctl   (bank_ctl[b]),
      .addr  (addr),
      .wdata (wdata2_r),
      .rdata (rd[b])
    );
  end

  logic                  out3_r;
  logic [WT_W-1:0]       w0_3_r, w1_3_r, w2_3_r;
  logic [BANK_SEL_W-1:0] c0_3_r, c1_3_r, c2_3_r;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      out3_r <= out2_r;
      w0_3_r <= w0_2_r;
      w1_3_r <= w1_2_r;
      w2_3_r <= w2_2_r;
      c0_3_r <= c0_2_r;
      c1_3_r <= c1_2_r;
      c2_3_r <= c2_2_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: pick corners and weight them
  // ---------------------------------------------------------------------------
  logic signed [PROD_W-1:0] p0_nxt, p1_nxt, p2_nxt;
  logic signed [PROD_W-1:0] p0_r, p1_r, p2_r;
  logic                     out4_r;

  assign p0_nxt = $signed(rd[c0_3_r]) * $signed({1'b0, w0_3_r});
  assign p1_nxt = $signed(rd[c1_3_r]) * $signed({1'b0, w1_3_r});
  assign p2_nxt = $signed(rd[c2_3_r]) * $signed({1'b0, w2_3_r});

  always_ff @(posedge clk) begin
    if (rdy4) begin
      out4_r <= out3_r;
      p0_r   <= p0_nxt;
      p1_r   <= p1_nxt;
      p2_r   <= p2_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: sum, round half up, output register
  // ---------------------------------------------------------------------------
  logic signed [ACC_W-1:0] acc;
  logic signed [HGT_W-1:0] out_height_r;
  logic                    out_outside_r;

  assign acc = ACC_W'(p0_r) + ACC_W'(p1_r) + ACC_W'(p2_r) + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (rdy_out) begin
      out_outside_r <= out4_r;
      out_height_r  <= out4_r ? '0 : acc[FRAC_BITS +: HGT_W];
    end
  end

  // Valid bits; writes leave the pipe after the store access
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1)    v1_r        <= in_valid;
      if (rdy2)    v2_r        <= v1_r;
      if (rdy3)    v3_r        <= is_query2;
      if (rdy4)    v4_r        <= v3_r;
      if (rdy_out) out_valid_r <= v4_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_height  = out_height_r;
  assign out_outside = out_outside_r;

`ifndef NO_ASSERTIONS
  // An outside query always reports zero height
  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_outside_r |-> out_height_r == '0)
    else $error("outside result with nonzero height");

  // A write item never reaches the multiply stage
  a_write_drops: assert property (@(posedge clk) disable iff (!rst_n)
    is_write2 && rdy3 |=> !v3_r)
    else $error("write item produced a result slot");

  // The three corners of a cell come from three different banks
  a_corner_banks: assert property (@(posedge clk) disable iff (!rst_n)
    is_query2 && !out2_r |->
      c0_2_r != c1_2_r && c1_2_r != c2_2_r && c0_2_r != c2_2_r)
    else $error("corner bank collision");

  // Barycentric weights add up to one
  a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
    is_query2 && !out2_r |->
      ((WT_W+2)'(w0_2_r) + (WT_W+2)'(w1_2_r) + (WT_W+2)'(w2_2_r)) == (WT_W+2)'(ONE_W))
    else $error("weights do not sum to one");

  // Bank read data of an inside query holds while stage 4 is blocked
  a_read_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !out3_r && !rdy4 |=> v3_r && $stable({rd[0], rd[1], rd[2], rd[3]}))
    else $error("bank read data changed under stall");
`endif

endmodule

// File: design/hmts_bank.sv
// hmts_bank: one single-port bank of the height store, registered read data.
// Depends on hmts_pkg (bank_ctl_t).
`timescale 1ns / 1ps

module hmts_bank
  import hmts_pkg::*;
#(
  parameter int AW = 14,
  parameter int DW = 16
) (
  input  logic          clk,
  input  bank_ctl_t     ctl,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  // One access per cycle: a write or a read, never both
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= wdata;
    end
    if (ctl.rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: sim/tb_top.sv
// tb_top: self-checking testbench for heightmap_triangle_sampler_top.
// Feeds write and query items with random idling, predicts each interpolated height
// from a local copy of the height store, and checks every result. Depends on hmts_pkg.
`timescale 1ns / 1ps

module tb_top;
  import hmts_pkg::*;

  localparam int     SIDE      = 256;
  localparam int     FRAC      = 8;
  localparam int     ONE       = 1 << FRAC;
  localparam longint POS_HI    = (longint'(1) << (POS_W - 1)) - 1;
  localparam longint POS_LO    = -(longint'(1) << (POS_W - 1));
  localparam int     DOG_LIMIT = 4000;  // cycles without any transfer
  localparam int     SETTLE    = 12;    // pipeline is 5 deep, store write lands at 3
  localparam int     SHOW_MAX  = 10;

  typedef struct {
    op_t                     op;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_z;
    logic [IDX_W-1:0]        col;
    logic [IDX_W-1:0]        row;
    logic signed [HGT_W-1:0] height_in;
  } terrain_item_t;

  typedef struct {
    logic signed [HGT_W-1:0] height;
    logic                    outside;
  } height_result_t;

  // DUT signals, all inputs known from time zero
  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    in_op = 1'b0;
  logic signed [POS_W-1:0] in_pos_x = '0;
  logic signed [POS_W-1:0] in_pos_z = '0;
  logic [IDX_W-1:0]        in_sample_col = '0;
  logic [IDX_W-1:0]        in_sample_row = '0;
  logic signed [HGT_W-1:0] in_sample_height = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [HGT_W-1:0] out_height;
  logic                    out_outside;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [CFG_AW-1:0]       paddr = '0;
  logic [CFG_DW-1:0]       pwdata = '0;
  logic [CFG_DW-1:0]       prdata;
  logic                    pready;

  heightmap_triangle_sampler_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_pos_x         (in_pos_x),
    .in_pos_z         (in_pos_z),
    .in_sample_col    (in_sample_col),
    .in_sample_row    (in_sample_row),
    .in_sample_height (in_sample_height),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_height       (out_height),
    .out_outside      (out_outside),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor state: register mirror and height store copy
  longint                  terrain_off_x = 0;
  longint                  terrain_off_z = 0;
  int                      grid_w_cfg = 256;
  int                      grid_l_cfg = 256;
  logic signed [HGT_W-1:0] height_copy [SIDE*SIDE];

  // Stimulus bookkeeping
  bit                      ever_written [SIDE*SIDE];
  int                      ready_cells [$];   // lower-left corner, all four corners written
  terrain_item_t           queued_items [$];
  height_result_t          heights_due [$];
  terrain_item_t           drive_item;
  bit                      slot_full = 1'b0;
  int                      items_made = 0;
  int                      send_idle_pct = 0;
  int                      recv_stall_pct = 0;
  int                      fail_count = 0;
  int                      idle_cycles = 0;

  function automatic int eff_side(int v);
    return (v > SIDE) ? SIDE : v;
  endfunction

  // Offset subtract and grid bound check; returns 1 when the cell is inside
  function automatic bit cell_split(longint px, longint pz, output longint tx, output longint tz);
    tx = px - terrain_off_x;
    tz = pz - terrain_off_z;
    if (tx < 0 || tz < 0)
      return 1'b0;
    if ((tx >>> FRAC) >= eff_side(grid_w_cfg) - 1 || (tz >>> FRAC) >= eff_side(grid_l_cfg) - 1)
      return 1'b0;
    return 1'b1;
  endfunction

  function automatic longint corner(longint c, longint r);
    return longint'(height_copy[r * SIDE + c]);
  endfunction

  // Applies one item to the store copy; returns 1 with the expected result for a query
  function automatic bit sample_terrain(input terrain_item_t it, output height_result_t res);
    longint tx, tz, gx, gz, fx, fz, acc, h;
    res.height  = '0;
    res.outside = 1'b1;
    if (it.op == OP_WRITE) begin
      height_copy[{it.row, it.col}] = it.height_in;
      return 1'b0;
    end
    if (!cell_split(it.pos_x, it.pos_z, tx, tz))
      return 1'b1;
    gx = tx >>> FRAC;
    gz = tz >>> FRAC;
    fx = tx & (ONE - 1);
    fz = tz & (ONE - 1);
    // lower triangle wins the diagonal
    if (fx + fz <= ONE)
      acc = (ONE - fx - fz) * corner(gx, gz) + fx * corner(gx + 1, gz)
          + fz * corner(gx, gz + 1);
    else
      acc = (ONE - fz) * corner(gx + 1, gz) + (fx + fz - ONE) * corner(gx + 1, gz + 1)
          + (ONE - fx) * corner(gx, gz + 1);
    // round half up: add half, then floor
    h = (acc + (ONE >>> 1)) >>> FRAC;
    if (h > 32767)
      h = 32767;
    if (h < -32768)
      h = -32768;
    res.height  = h[HGT_W-1:0];
    res.outside = 1'b0;
    return 1'b1;
  endfunction

  function automatic longint rand_pos();
    logic signed [POS_W-1:0] p;
    p = POS_W'($urandom);
    return longint'(p);
  endfunction

  function automatic int rand_height();
    logic signed [HGT_W-1:0] v;
    case ($urandom_range(7))
      0: v = -16'sd32768;
      1: v = 16'sd32767;
      default: v = HGT_W'($urandom);
    endcase
    return int'(v);
  endfunction

  // Don't-care fields still toggle
  function automatic terrain_item_t random_fill();
    terrain_item_t it;
    it.op        = OP_WRITE;
    it.pos_x     = POS_W'($urandom);
    it.pos_z     = POS_W'($urandom);
    it.col       = IDX_W'($urandom);
    it.row       = IDX_W'($urandom);
    it.height_in = HGT_W'($urandom);
    return it;
  endfunction

  function automatic void push_write(int col, int row, int h);
    terrain_item_t it;
    it           = random_fill();
    it.op        = OP_WRITE;
    it.col       = col[IDX_W-1:0];
    it.row       = row[IDX_W-1:0];
    it.height_in = h[HGT_W-1:0];
    ever_written[row * SIDE + col] = 1'b1;
    queued_items.push_back(it);
    items_made++;
  endfunction

  // Queues a query unless the position cannot be encoded or an inside cell
  // would touch a sample that was never written
  function automatic bit push_query(longint px, longint pz);
    terrain_item_t it;
    longint tx, tz;
    int base;
    if (px < POS_LO || px > POS_HI || pz < POS_LO || pz > POS_HI)
      return 1'b0;
    if (cell_split(px, pz, tx, tz)) begin
      base = int'((tz >>> FRAC) * SIDE + (tx >>> FRAC));
      if (!(ever_written[base] && ever_written[base + 1] &&
            ever_written[base + SIDE] && ever_written[base + SIDE + 1]))
        return 1'b0;
    end
    it       = random_fill();
    it.op    = OP_QUERY;
    it.pos_x = px[POS_W-1:0];
    it.pos_z = pz[POS_W-1:0];
    queued_items.push_back(it);
    items_made++;
    return 1'b1;
  endfunction

  function automatic void pick_frac(output int fx, output int fz);
    case ($urandom_range(7))
      0: begin fx = $urandom_range(1, ONE - 1); fz = ONE - fx; end  // on the diagonal
      1: begin fx = 0; fz = 0; end
      2: begin fx = ONE - 1; fz = ONE - 1; end
      default: begin fx = $urandom_range(ONE - 1); fz = $urandom_range(ONE - 1); end
    endcase
  endfunction

  function automatic bit query_in_cell(int spot);
    int fx, fz;
    pick_frac(fx, fz);
    return push_query(terrain_off_x + longint'(spot % SIDE) * ONE + fx,
                      terrain_off_z + longint'(spot / SIDE) * ONE + fz);
  endfunction

  // Directed items under reset settings: corner extremes, both triangles, the
  // diagonal tie, the far grid edge, negative and huge positions
  task automatic load_directed();
    push_write(0, 0, -32768);
    push_write(1, 0, 32767);
    push_write(0, 1, 256);
    push_write(1, 1, -1);
    push_write(254, 254, 32767);
    push_write(255, 254, -32768);
    push_write(254, 255, 32767);
    push_write(255, 255, 32767);
    ready_cells.push_back(0);
    ready_cells.push_back(254 * SIDE + 254);
    void'(push_query(0, 0));
    void'(push_query(255, 0));
    void'(push_query(0, 255));
    void'(push_query(128, 128));
    void'(push_query(129, 128));
    void'(push_query(255, 255));
    void'(push_query(127, 1));
    void'(push_query(254 * ONE + 255, 254 * ONE + 255));
    void'(push_query(255 * ONE, 0));
    void'(push_query(-1, 0));
    void'(push_query(0, POS_LO));
    void'(push_query(POS_HI, POS_HI));
  endtask

  // Mostly well-formed: write a cell's corners then query inside it, or revisit
  // a known cell; the rest are stray writes and arbitrary positions
  task automatic gen_random(int n);
    int goal, sel, gx, gz, wl, ll, spot;
    goal = items_made + n;
    while (items_made < goal) begin
      sel = $urandom_range(99);
      wl  = eff_side(grid_w_cfg);
      ll  = eff_side(grid_l_cfg);
      if (sel < 30) begin
        gx = (wl >= 2) ? $urandom_range(wl - 2) : $urandom_range(SIDE - 2);
        gz = (ll >= 2) ? $urandom_range(ll - 2) : $urandom_range(SIDE - 2);
        push_write(gx, gz, rand_height());
        push_write(gx + 1, gz, rand_height());
        push_write(gx, gz + 1, rand_height());
        push_write(gx + 1, gz + 1, rand_height());
        ready_cells.push_back(gz * SIDE + gx);
        repeat ($urandom_range(1, 3)) void'(query_in_cell(gz * SIDE + gx));
      end else if (sel < 70) begin
        spot = ready_cells[$urandom_range(ready_cells.size() - 1)];
        void'(query_in_cell(spot));
      end else if (sel < 85) begin
        push_write($urandom_range(SIDE - 1), $urandom_range(SIDE - 1), rand_height());
      end else if (sel < 93) begin
        void'(push_query(rand_pos(), rand_pos()));
      end else begin
        void'(push_query(terrain_off_x + $urandom_range(64 * ONE) - 300,
                         terrain_off_z + $urandom_range(64 * ONE) - 300));
      end
    end
  endtask

  task automatic note_mismatch(string msg);
    fail_count++;
    if (fail_count <= SHOW_MAX)
      $display("mismatch: %s", msg);
  endtask

  // APB write, mirror update, then read back the register
  task automatic cfg_write(logic [1:0] idx, int value);
    logic [CFG_DW-1:0] mask;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_OFFSET_X:    terrain_off_x = longint'($signed(value[POS_W-1:0]));
      REG_OFFSET_Z:    terrain_off_z = longint'($signed(value[POS_W-1:0]));
      REG_GRID_WIDTH:  grid_w_cfg = int'(value[GRID_W-1:0]);
      REG_GRID_LENGTH: grid_l_cfg = int'(value[GRID_W-1:0]);
    endcase
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    mask = (idx == REG_OFFSET_X || idx == REG_OFFSET_Z) ? 32'hFF_FFFF : 32'h1FF;
    if (((prdata ^ value) & mask) !== '0)
      note_mismatch($sformatf("register %0d read back %h, wrote %h", idx, prdata, value));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_drained();
    while (queued_items.size() != 0 || slot_full || heights_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Driver: new item only once the previous one was taken
  always @(negedge clk) begin
    if (rst_n) begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
      if (!slot_full) begin
        if (queued_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drive_item        = queued_items.pop_front();
          in_op            <= drive_item.op;
          in_pos_x         <= drive_item.pos_x;
          in_pos_z         <= drive_item.pos_z;
          in_sample_col    <= drive_item.col;
          in_sample_row    <= drive_item.row;
          in_sample_height <= drive_item.height_in;
          in_valid         <= 1'b1;
          slot_full         = 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: predict on input acceptance first, then check the result side
  always @(posedge clk) begin : monitor
    height_result_t want;
    bit moved;
    moved = 1'b0;
    if (rst_n) begin
      if (slot_full && in_valid && !in_stall) begin
        if (sample_terrain(drive_item, want))
          heights_due.push_back(want);
        slot_full = 1'b0;
        moved     = 1'b1;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (heights_due.size() == 0) begin
          note_mismatch($sformatf("unexpected result height %0d outside %0b",
                                  out_height, out_outside));
        end else begin
          want = heights_due.pop_front();
          if (out_height !== want.height || out_outside !== want.outside)
            note_mismatch($sformatf("expected height %0d outside %0b, got height %0d outside %0b",
                                    want.height, want.outside, out_height, out_outside));
        end
      end
    end
    if (moved || psel)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= DOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Phases: reset settings, offset and grid extremes, then two typical setups
  initial begin
    send_idle_pct  = 7;
    recv_stall_pct = 50;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    load_directed();
    wait_drained();

    // smallest grid with one cell, opposite offset extremes
    cfg_write(REG_OFFSET_X, -8388608);
    cfg_write(REG_OFFSET_Z, 8388607);
    cfg_write(REG_GRID_WIDTH, 2);
    cfg_write(REG_GRID_LENGTH, 2);
    gen_random(80);
    wait_drained();

    // no cell along x, length above the store size
    cfg_write(REG_OFFSET_X, 8388607);
    cfg_write(REG_OFFSET_Z, -8388608);
    cfg_write(REG_GRID_WIDTH, 1);
    cfg_write(REG_GRID_LENGTH, 511);
    gen_random(50);
    wait_drained();

    send_idle_pct  = 50;
    recv_stall_pct = 7;
    cfg_write(REG_OFFSET_X, 32'h0000_0C80);
    cfg_write(REG_OFFSET_Z, -4096);
    cfg_write(REG_GRID_WIDTH, 511);
    cfg_write(REG_GRID_LENGTH, 20);
    gen_random(500);
    wait_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cfg_write(REG_OFFSET_X, -837);
    cfg_write(REG_OFFSET_Z, 16);
    cfg_write(REG_GRID_WIDTH, 40);
    cfg_write(REG_GRID_LENGTH, 256);
    gen_random(500);
    wait_drained();

    if (fail_count == 0 && heights_due.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: files.f
design/hmts_pkg.sv
design/hmts_bank.sv
design/heightmap_triangle_sampler_top.sv
sim/tb_top.sv
